/* src/pulse_meter_counter_with_query_assert.svh */
// Assertion macros shared by the checker of the pulse meter block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PULSE_METER_COUNTER_WITH_QUERY_ASSERT_SVH
`define PULSE_METER_COUNTER_WITH_QUERY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmq assertion failed");

`endif

/* src/pmq_pkg.sv */
// Package of the pulse meter block: payload types, job codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pmq_pkg;

  // Width of the pulse counts.
  localparam int COUNT_WIDTH = 32;

  // Field and register widths.
  localparam int TEMP_W     = 12;
  localparam int DIV_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BIN_W      = 32;
  localparam int DIGITS     = 10;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int DIG_W      = $clog2(DIGITS + 1);

  // Reply queue between front and back.
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WATER_DIV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEC_DIV  = 1'd1;

  // Reset values of the dividers.
  localparam logic [DIV_W-1:0] WATER_DIV_RST = 16'd1;
  localparam logic [DIV_W-1:0] ELEC_DIV_RST  = 16'd640;

  // Input actions.
  localparam logic [1:0] ACT_WATER   = 2'd0;
  localparam logic [1:0] ACT_ELEC    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_BYTE    = 2'd3;

  // Characters.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CMD_WATER  = 8'h61;
  localparam logic [7:0] CMD_ELEC   = 8'h62;
  localparam logic [7:0] CMD_TEMP   = 8'h63;
  localparam logic [7:0] CMD_CLR_W  = 8'h64;
  localparam logic [7:0] CMD_CLR_E  = 8'h65;

  // Reply kinds.
  localparam logic [1:0] K_DEC = 2'd0;
  localparam logic [1:0] K_OK  = 2'd1;
  localparam logic [1:0] K_UNK = 2'd2;

  // Lengths of the text replies, without the closing carriage return.
  localparam logic [DIG_W-1:0] TXT_OK_LEN  = DIG_W'(2);
  localparam logic [DIG_W-1:0] TXT_UNK_LEN = DIG_W'(7);

  typedef struct packed {
    logic [1:0]               action;
    logic [7:0]               rx_byte;
    logic                     rx_error;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_char;
    logic       last;
  } out_item_t;

  // One reply to produce.
  typedef struct packed {
    logic [1:0]       kind;
    logic [BIN_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/pmq_queue.sv */
// Short reply queue between the command front end and the reply engine.
// Depends on pmq_pkg.
`timescale 1ns / 1ps

module pmq_queue import pmq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  // Status and head of the queue.
  assign q_stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = q_mem_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/pmq_front.sv */
// Front end: accepts input beats, runs the prescalers, the debounce flag and
// the command register, and queues one reply job per carriage return.
// Depends on pmq_pkg.
`timescale 1ns / 1ps

module pmq_front import pmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_data,
  input  q_stat_t              q_stat,
  output logic                 push,
  output job_t                 push_data
);

  logic [DIV_W-1:0]       wdiv_r, wdiv_nxt;
  logic [DIV_W-1:0]       ediv_r, ediv_nxt;
  logic [COUNT_WIDTH-1:0] wc_r, wc_nxt;
  logic [COUNT_WIDTH-1:0] ec_r, ec_nxt;
  logic [DIV_W-1:0]       wt_r, wt_nxt;
  logic [DIV_W-1:0]       et_r, et_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic                   busy_r, busy_nxt;
  logic                   accept;
  logic [DIV_W-1:0]       wt_inc, et_inc;
  logic [BIN_W-1:0]       temp_ext;

  // Input stalls only while both reply slots are taken.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign wt_inc   = wt_r + DIV_W'(1);
  assign et_inc   = et_r + DIV_W'(1);
  assign temp_ext = {{(BIN_W - TEMP_W){in_data.temperature[TEMP_W-1]}}, in_data.temperature};

  // A carriage return without error queues a reply.
  assign push = accept && (in_data.action == ACT_BYTE) && !in_data.rx_error &&
                (in_data.rx_byte == CHAR_CR);

  // Reply job from the pending command, counts taken at this beat.
  always_comb begin
    push_data.kind  = K_UNK;
    push_data.value = '0;
    case (pend_r) inside
      CMD_WATER: begin
        push_data.kind  = K_DEC;
        push_data.value = BIN_W'(wc_r);
      end
      CMD_ELEC: begin
        push_data.kind  = K_DEC;
        push_data.value = BIN_W'(ec_r);
      end
      CMD_TEMP: begin
        push_data.kind  = K_DEC;
        push_data.value = temp_ext;
      end
      CMD_CLR_W, CMD_CLR_E: begin
        push_data.kind = K_OK;
      end
      default: begin
        push_data.kind = K_UNK;
      end
    endcase
  end

  // Next state of counters, dividers and command register.
  always_comb begin
    wdiv_nxt = wdiv_r;
    ediv_nxt = ediv_r;
    wc_nxt   = wc_r;
    ec_nxt   = ec_r;
    wt_nxt   = wt_r;
    et_nxt   = et_r;
    pend_nxt = pend_r;
    busy_nxt = busy_r;

    if (cfg_we) begin
      if (cfg_index == REG_WATER_DIV) begin
        wdiv_nxt = cfg_data;
      end else if (cfg_index == REG_ELEC_DIV) begin
        ediv_nxt = cfg_data;
      end
    end

    if (accept) begin
      case (in_data.action)
        ACT_WATER: begin
          // Debounced: one pulse per timeout.
          if (!busy_r) begin
            busy_nxt = 1'b1;
            if (wt_inc >= wdiv_r) begin
              wt_nxt = '0;
              wc_nxt = wc_r + COUNT_WIDTH'(1);
            end else begin
              wt_nxt = wt_inc;
            end
          end
        end
        ACT_ELEC: begin
          if (et_inc >= ediv_r) begin
            et_nxt = '0;
            ec_nxt = ec_r + COUNT_WIDTH'(1);
          end else begin
            et_nxt = et_inc;
          end
        end
        ACT_TIMEOUT: begin
          busy_nxt = 1'b0;
        end
        default: begin
          if (!in_data.rx_error) begin
            if (in_data.rx_byte == CHAR_CR) begin
              // Clear commands act here; their reply is just the text.
              if (pend_r == CMD_CLR_W) begin
                wc_nxt = '0;
              end else if (pend_r == CMD_CLR_E) begin
                ec_nxt = '0;
              end
            end else if (in_data.rx_byte != CHAR_LF) begin
              pend_nxt = in_data.rx_byte;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdiv_r <= WATER_DIV_RST;
      ediv_r <= ELEC_DIV_RST;
      wc_r   <= '0;
      ec_r   <= '0;
      wt_r   <= '0;
      et_r   <= '0;
      pend_r <= '0;
      busy_r <= 1'b0;
    end else begin
      wdiv_r <= wdiv_nxt;
      ediv_r <= ediv_nxt;
      wc_r   <= wc_nxt;
      ec_r   <= ec_nxt;
      wt_r   <= wt_nxt;
      et_r   <= et_nxt;
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

/* src/pmq_back.sv */
// Reply engine: takes jobs from the queue, converts numbers to decimal by
// shift-and-add-3 one bit per cycle, and sends characters through an output
// register. Depends on pmq_pkg.
`timescale 1ns / 1ps

module pmq_back import pmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(BIN_W);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CONV = 3'd1;
  localparam logic [2:0] B_TRIM = 3'd2;
  localparam logic [2:0] B_EMIT = 3'd3;
  localparam logic [2:0] B_END  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             slot_free;
  logic [3:0]       top_digit;
  logic [BCD_W-1:0] bcd_adj;

  // Add 3 to every decimal digit of five or more before the shift.
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Characters of the text replies.
  function automatic logic [7:0] text_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h3F;
    if (kind == K_OK) begin
      c = (idx == 3'd0) ? 8'h4F : 8'h4B;
    end else begin
      case (idx)
        3'd0:    c = 8'h75;
        3'd1:    c = 8'h6E;
        3'd2:    c = 8'h6B;
        3'd3:    c = 8'h6E;
        3'd4:    c = 8'h6F;
        3'd5:    c = 8'h77;
        3'd6:    c = 8'h6E;
        default: c = 8'h3F;
      endcase
    end
    return c;
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign bcd_adj   = dabble_adj(bcd_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer for conversion and character output.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          kind_nxt = head.kind;
          idx_nxt  = '0;
          if (head.kind == K_DEC) begin
            bin_nxt   = head.value;
            bcd_nxt   = '0;
            cnt_nxt   = CNT_W'(BIN_W - 1);
            state_nxt = B_CONV;
          end else begin
            dig_nxt   = (head.kind == K_OK) ? TXT_OK_LEN : TXT_UNK_LEN;
            state_nxt = B_EMIT;
          end
        end
      end
      B_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          dig_nxt   = DIG_W'(DIGITS);
          state_nxt = B_TRIM;
        end
      end
      B_TRIM: begin
        // Drop leading zeros, keeping at least one digit.
        if ((top_digit == 4'd0) && (dig_r > DIG_W'(1))) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt = dig_r - DIG_W'(1);
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.tx_char = (kind_r == K_DEC) ? {4'h3, top_digit} :
                                 text_char(kind_r, idx_r);
          out_data_nxt.last    = 1'b0;
          bcd_nxt              = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt              = dig_r - DIG_W'(1);
          idx_nxt              = idx_r + 3'd1;
          if (dig_r == DIG_W'(1)) begin
            state_nxt = B_END;
          end
        end
      end
      B_END: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.tx_char = CHAR_CR;
          out_data_nxt.last    = 1'b1;
          state_nxt            = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      kind_r      <= K_DEC;
      cnt_r       <= '0;
      dig_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      dig_r       <= dig_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* src/pulse_meter_counter_with_query.sv */
// Channel  | Dir | Handshake          | Beat
// in_      | in  | in_valid/in_stall  | in_item_t: action, rx_byte, rx_error, temperature
// out_     | out | out_valid/out_stall| out_item_t: tx_char, last
// cfg_     | in  | cfg_we             | cfg_index selects divider, cfg_data is the value
//
// Pulses, timeouts and ordinary bytes are handled by the front end as each beat is accepted.
// A decimal reply is dequeued, converted bit by bit in the shift-and-add-3 loop,
// stripped of leading zeros, then sent one character per cycle while out_stall allows.
// Text replies are dequeued and then sent one character per cycle while out_stall allows.
// in_stall rises only while two replies wait in the queue; out_stall holds the
// output register. Reset is synchronous; no clearing pass is needed.
//
// Top level of the pulse meter block; depends on pmq_pkg, pmq_front,
// pmq_queue and pmq_back.
`timescale 1ns / 1ps

module pulse_meter_counter_with_query import pmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_data
);

  q_stat_t q_stat;
  job_t    push_data;
  job_t    head;
  logic    push;
  logic    pop;

  // Command front end.
  pmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Reply job queue.
  pmq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Reply engine.
  pmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/pmq_checker.sv */
// Port-level checker for the pulse meter block, bound to the top level.
// Depends on pmq_pkg and pulse_meter_counter_with_query_assert.svh.
`timescale 1ns / 1ps
`include "pulse_meter_counter_with_query_assert.svh"

module pmq_checker import pmq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled output beat is held unchanged.
  `PMQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Only the closing beat of a reply carries a carriage return.
  `PMQ_ASSERT_NOW(a_last_is_cr, out_valid, out_data.last == (out_data.tx_char == CHAR_CR))

  // The queue fills only through an accepted input beat.
  `PMQ_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind pulse_meter_counter_with_query pmq_checker u_pmq_checker (.*);
